// ----- design/relay_stage_sequencer_core_assert.svh -----
`ifndef RELAY_STAGE_SEQUENCER_CORE_ASSERT_SVH
`define RELAY_STAGE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define RSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("relay sequencer check failed");

// next-cycle implication
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("relay sequencer check failed");

`endif

// ----- design/rss_pkg.sv -----
package rss_pkg;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam int TIME_W      = 32;
	localparam int SEQ_SEL_W   = 3;
	localparam int STAGE_NUM_W = 5;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [SEQ_SEL_W-1:0] seq_select;
		logic                 first_stage;
		logic [TIME_W-1:0]    stage_duration;
		logic [TIME_W-1:0]    now_time;
	} item_t;

	typedef struct packed {
		logic                   relay_level;
		logic                   running;
		logic [STAGE_NUM_W-1:0] stage_number;
		logic                   finished;
		logic                   load_rejected;
	} result_t;

endpackage

// ----- design/rss_ram.sv -----
module rss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/rss_ctrl.sv -----
`include "relay_stage_sequencer_core_assert.svh"

module rss_ctrl #(
	parameter int NUM_SEQUENCES = 8,
	parameter int MAX_STAGES    = 16,
	localparam int SEQ_IW = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1,
	localparam int STG_IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
	localparam int CNT_W  = $clog2(MAX_STAGES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       commit,
	input  rss_pkg::item_t             item,
	input  logic [SEQ_IW-1:0]          seq_idx,
	input  logic                       seq_ok,
	input  logic [CNT_W-1:0]           cnt,
	input  logic [rss_pkg::TIME_W-1:0] mem_end,
	output logic [SEQ_IW-1:0]          la_seq,
	output logic [CNT_W-1:0]           la_idx,
	output logic                       cnt_we,
	output logic [CNT_W-1:0]           cnt_wval,
	output logic                       mem_we,
	output logic [STG_IW-1:0]          mem_wstage,
	output logic [rss_pkg::TIME_W-1:0] mem_wdata,
	output rss_pkg::result_t           res
);

	localparam int TW = rss_pkg::TIME_W;

	logic              active_q, relay_q;
	logic [SEQ_IW-1:0] seq_q;
	logic [TW-1:0]     start_q;
	logic [CNT_W-1:0]  idx_q, act_cnt_q;

	logic              nxt_active, nxt_relay, fin, rej;
	logic [SEQ_IW-1:0] nxt_seq;
	logic [TW-1:0]     nxt_start;
	logic [CNT_W-1:0]  nxt_idx, nxt_act_cnt, eff_cnt, idx_inc;
	logic [TW:0]       sum_end, limit;
	logic              late;

	assign eff_cnt = item.first_stage ? '0 : cnt;
	assign sum_end = {1'b0, item.stage_duration} + ((eff_cnt != '0) ? {1'b0, mem_end} : '0);
	assign limit   = {1'b0, mem_end} + {1'b0, start_q};
	assign late    = limit < {1'b0, item.now_time};
	assign idx_inc = idx_q + 1'b1;

	always_comb begin
		nxt_active  = active_q;
		nxt_relay   = relay_q;
		nxt_seq     = seq_q;
		nxt_start   = start_q;
		nxt_idx     = idx_q;
		nxt_act_cnt = act_cnt_q;
		fin         = 1'b0;
		rej         = 1'b0;
		cnt_we      = 1'b0;
		cnt_wval    = eff_cnt + 1'b1;
		mem_we      = 1'b0;
		mem_wstage  = eff_cnt[STG_IW-1:0];
		mem_wdata   = sum_end[TW] ? '1 : sum_end[TW-1:0];
		unique case (item.opcode)
			rss_pkg::OP_LOAD: begin
				if (active_q || !seq_ok || eff_cnt >= CNT_W'(MAX_STAGES)) begin
					rej = 1'b1;
				end else begin
					cnt_we = 1'b1;
					mem_we = 1'b1;
				end
			end
			rss_pkg::OP_START: begin
				if (!active_q && seq_ok && cnt != '0) begin
					nxt_active  = 1'b1;
					nxt_seq     = seq_idx;
					nxt_start   = item.now_time;
					nxt_idx     = '0;
					nxt_act_cnt = cnt;
				end
			end
			rss_pkg::OP_TICK: begin
				if (active_q) begin
					if (idx_q >= act_cnt_q) begin
						nxt_active = 1'b0;
						nxt_relay  = 1'b0;
						fin        = 1'b1;
					end else begin
						nxt_relay = ~idx_q[0];
						if (late) begin
							nxt_idx = idx_inc;
							if (idx_inc >= act_cnt_q) begin
								nxt_active = 1'b0;
								nxt_relay  = 1'b0;
								fin        = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			relay_q   <= 1'b0;
			seq_q     <= '0;
			start_q   <= '0;
			idx_q     <= '0;
			act_cnt_q <= '0;
		end else if (commit) begin
			active_q  <= nxt_active;
			relay_q   <= nxt_relay;
			seq_q     <= nxt_seq;
			start_q   <= nxt_start;
			idx_q     <= nxt_idx;
			act_cnt_q <= nxt_act_cnt;
		end
	end

	assign la_seq = commit ? nxt_seq : seq_q;
	assign la_idx = commit ? nxt_idx : idx_q;

	assign res.relay_level   = nxt_relay;
	assign res.running       = nxt_active;
	assign res.stage_number  = nxt_active ? rss_pkg::STAGE_NUM_W'(nxt_idx) : '0;
	assign res.finished      = fin;
	assign res.load_rejected = rej;

	`RSS_ASSERT_NEXT(a_fin_idle, clk, arst_n, commit && fin, !active_q && !relay_q)
	`RSS_ASSERT_NOW(a_idx_range, clk, arst_n, active_q, idx_q < act_cnt_q)
	`RSS_ASSERT_NOW(a_cnt_nonzero, clk, arst_n, active_q, act_cnt_q != '0)
	`RSS_ASSERT_NOW(a_load_idle, clk, arst_n, commit && mem_we, !active_q && !rej)

endmodule

// ----- design/relay_stage_sequencer_core.sv -----
// Pipeline: a word taken on the input is held in the s1 registers; its result
// word is registered into res_q, driven on m_tdata, when the s1 word commits.
// Throughput: one word per cycle when the output is not stalled; the stage-end
// table RAM is read once per accepted word, written once per unrejected load.
// Reset: clears sequencer state, stage counts and the handshake registers;
// the stage-end table is not cleared and needs no clearing pass.
module relay_stage_sequencer_core #(
	parameter int NUM_SEQUENCES = 8,
	parameter int MAX_STAGES    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// seq_select, first_stage, stage_duration, now_time, zero fill
	input  logic [71:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// relay_level, running, stage_number, finished, load_rejected, zero fill
	output logic [15:0] m_tdata
);

	localparam int TW     = rss_pkg::TIME_W;
	localparam int SEQ_IW = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
	localparam int SEQ_XW = (SEQ_IW > rss_pkg::SEQ_SEL_W) ? SEQ_IW : rss_pkg::SEQ_SEL_W;
	localparam int STG_IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CNT_W  = $clog2(MAX_STAGES + 1);
	localparam int DEPTH  = NUM_SEQUENCES * MAX_STAGES;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [AW-1:0] slot(input logic [SEQ_IW-1:0] s,
			input logic [STG_IW-1:0] i);
		slot = AW'(AW'(s) * AW'(MAX_STAGES)) + AW'(i);
	endfunction

	rss_pkg::item_t   in_item, item_s1;
	rss_pkg::result_t res, res_q;

	logic              valid_s1, seq_ok_s1, byp_s1, m_valid_q;
	logic [SEQ_IW-1:0] seq_idx_s1, in_seq_idx, la_seq;
	logic [CNT_W-1:0]  cnt_s1, cnt_rd, cnt_wval, la_idx, rd_stage;
	logic [TW-1:0]     byp_data_s1, ram_rdata, mem_end, mem_wdata;
	logic [SEQ_XW-1:0] in_seq_ext;
	logic              in_seq_ok, commit, accept, cnt_we, mem_we, ram_we, byp;
	logic [STG_IW-1:0] mem_wstage;
	logic [AW-1:0]     raddr, waddr;
	logic [CNT_W-1:0]  counts_q [NUM_SEQUENCES];

	assign in_item.opcode         = s_tuser;
	assign in_item.seq_select     = s_tdata[2:0];
	assign in_item.first_stage    = s_tdata[3];
	assign in_item.stage_duration = s_tdata[35:4];
	assign in_item.now_time       = s_tdata[67:36];

	assign in_seq_ext = SEQ_XW'(in_item.seq_select);
	assign in_seq_ok  = {1'b0, in_seq_ext} < (SEQ_XW + 1)'(NUM_SEQUENCES);
	assign in_seq_idx = in_seq_ext[SEQ_IW-1:0];

	assign commit   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || commit;
	assign accept   = s_tvalid && s_tready;

	// count seen by the incoming word, including the write of the word ahead
	always_comb begin
		cnt_rd = in_seq_ok ? counts_q[in_seq_idx] : '0;
		if (commit && cnt_we && seq_idx_s1 == in_seq_idx) begin
			cnt_rd = cnt_wval;
		end
	end

	assign rd_stage = cnt_rd - 1'b1;
	assign raddr = (in_item.opcode == rss_pkg::OP_LOAD) ? slot(in_seq_idx, rd_stage[STG_IW-1:0])
			: slot(la_seq, la_idx[STG_IW-1:0]);
	assign waddr  = slot(seq_idx_s1, mem_wstage);
	assign ram_we = commit && mem_we;
	assign byp    = ram_we && (waddr == raddr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			seq_idx_s1  <= in_seq_idx;
			seq_ok_s1   <= in_seq_ok;
			cnt_s1      <= cnt_rd;
			byp_s1      <= byp;
			byp_data_s1 <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEQUENCES; i++) begin
				counts_q[i] <= '0;
			end
		end else if (commit && cnt_we) begin
			counts_q[seq_idx_s1] <= cnt_wval;
		end
	end

	rss_ram #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_stage_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign mem_end = byp_s1 ? byp_data_s1 : ram_rdata;

	rss_ctrl #(
		.NUM_SEQUENCES(NUM_SEQUENCES),
		.MAX_STAGES   (MAX_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.item      (item_s1),
		.seq_idx   (seq_idx_s1),
		.seq_ok    (seq_ok_s1),
		.cnt       (cnt_s1),
		.mem_end   (mem_end),
		.la_seq    (la_seq),
		.la_idx    (la_idx),
		.cnt_we    (cnt_we),
		.cnt_wval  (cnt_wval),
		.mem_we    (mem_we),
		.mem_wstage(mem_wstage),
		.mem_wdata (mem_wdata),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, res_q.load_rejected, res_q.finished, res_q.stage_number,
			res_q.running, res_q.relay_level};

endmodule
